// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is high.
`define FTTF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FTTF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fttf_pkg.sv =====
// Package: field widths, register indexes and the FP32 to FP16 truncation.
package fttf_pkg;

  localparam int WORD_W      = 32;
  localparam int INDEX_W     = 22;
  localparam int HEADS_REG_W = 7;
  localparam int DIM_REG_W   = 9;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 9;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_HEADS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_DIM     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_DIM   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_HALF = 2'd3;

  localparam int F32_BIAS = 127;
  localparam int F16_BIAS = 15;
  localparam int F16_EMAX = 15;
  localparam int F16_EMIN = -14;
  localparam logic [15:0] F16_INF = 16'h7C00;

  // Truncating FP32 -> FP16: overflow (incl. NaN) to inf, underflow to zero.
  function automatic logic [15:0] to_half(input logic [WORD_W-1:0] w);
    logic [15:0] sgn;
    int          ex;
    logic [15:0] res;
    sgn = {w[31], 15'b0};
    ex  = int'(w[30:23]) - F32_BIAS;
    if (ex > F16_EMAX) begin
      res = sgn | F16_INF;
    end else if (ex < F16_EMIN) begin
      res = sgn;
    end else begin
      res = sgn | {1'b0, 5'(ex + F16_BIAS), w[22:13]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/fttf_if.sv =====
// Stream interfaces: input word channel and result channel.
interface fttf_in_if;
  logic                           valid;
  logic                           ready;
  logic [fttf_pkg::WORD_W-1:0]    source_word;

  modport source (output valid, output source_word, input ready);
  modport sink (input valid, input source_word, output ready);
endinterface

interface fttf_out_if;
  logic                           valid;
  logic                           ready;
  logic [fttf_pkg::INDEX_W-1:0]   dest_index;
  logic [fttf_pkg::WORD_W-1:0]    dest_word;
  logic                           end_of_tensor;

  modport source (output valid, output dest_index, output dest_word,
                  output end_of_tensor, input ready);
  modport sink (input valid, input dest_index, input dest_word,
                input end_of_tensor, output ready);
endinterface

// ===== rtl/core/fttf_cfg.sv =====
// Config registers: clamped dimensions, plane size and output format.
module fttf_cfg #(
  parameter int MAX_HEADS = 64,
  parameter int MAX_DIM   = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fttf_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [fttf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [$clog2(MAX_HEADS+1)-1:0]     nh,
  output logic [$clog2(MAX_DIM+1)-1:0]       nk,
  output logic [$clog2(MAX_DIM+1)-1:0]       nv,
  output logic [2*$clog2(MAX_DIM+1)-1:0]     plane,
  output logic                               half
);

  localparam int NHW = $clog2(MAX_HEADS+1);
  localparam int NDW = $clog2(MAX_DIM+1);
  localparam int PW  = 2*NDW;

  function automatic logic [NHW-1:0] clamp_heads(
    input logic [fttf_pkg::HEADS_REG_W-1:0] v);
    logic [31:0] v32;
    logic [31:0] r;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      r = 32'd1;
    end else if (v32 > 32'(MAX_HEADS)) begin
      r = 32'(MAX_HEADS);
    end else begin
      r = v32;
    end
    return r[NHW-1:0];
  endfunction

  function automatic logic [NDW-1:0] clamp_dim(
    input logic [fttf_pkg::DIM_REG_W-1:0] v);
    logic [31:0] v32;
    logic [31:0] r;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      r = 32'd1;
    end else if (v32 > 32'(MAX_DIM)) begin
      r = 32'(MAX_DIM);
    end else begin
      r = v32;
    end
    return r[NDW-1:0];
  endfunction

  logic [NDW-1:0] dim_w;
  logic [PW-1:0]  plane_k;
  logic [PW-1:0]  plane_v;

  assign dim_w   = clamp_dim(cfg_wdata[fttf_pkg::DIM_REG_W-1:0]);
  assign plane_k = dim_w * nv;
  assign plane_v = nk * dim_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      nh    <= NHW'(1);
      nk    <= NDW'(1);
      nv    <= NDW'(1);
      plane <= PW'(1);
      half  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fttf_pkg::CFG_NUM_HEADS: begin
          nh <= clamp_heads(cfg_wdata[fttf_pkg::HEADS_REG_W-1:0]);
        end
        fttf_pkg::CFG_KEY_DIM: begin
          nk    <= dim_w;
          plane <= plane_k;
        end
        fttf_pkg::CFG_VALUE_DIM: begin
          nv    <= dim_w;
          plane <= plane_v;
        end
        fttf_pkg::CFG_TARGET_HALF: begin
          half <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fttf_counter.sv =====
// Source position counters: value fastest, then key, then head.
module fttf_counter #(
  parameter int MAX_HEADS = 64,
  parameter int MAX_DIM   = 256
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              advance,
  input  logic [$clog2(MAX_HEADS+1)-1:0]                    nh,
  input  logic [$clog2(MAX_DIM+1)-1:0]                      nk,
  input  logic [$clog2(MAX_DIM+1)-1:0]                      nv,
  output logic [(MAX_HEADS > 1 ? $clog2(MAX_HEADS) : 1)-1:0] head_count,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]     key_count,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]     value_count,
  output logic                                              last_elem
);

  localparam int CHW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int CDW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic           last_v;
  logic           last_k;
  logic           last_h;
  logic [CHW-1:0] head_count_next;
  logic [CDW-1:0] key_count_next;
  logic [CDW-1:0] value_count_next;

  // a counter at or past its last index counts as on it (dims may shrink)
  assign last_v    = (32'(value_count) + 32'd1) >= 32'(nv);
  assign last_k    = (32'(key_count) + 32'd1) >= 32'(nk);
  assign last_h    = (32'(head_count) + 32'd1) >= 32'(nh);
  assign last_elem = last_v && last_k && last_h;

  always_comb begin
    head_count_next  = head_count;
    key_count_next   = key_count;
    value_count_next = value_count;
    if (!last_v) begin
      value_count_next = value_count + CDW'(1);
    end else begin
      value_count_next = '0;
      if (!last_k) begin
        key_count_next = key_count + CDW'(1);
      end else begin
        key_count_next = '0;
        head_count_next = last_h ? '0 : head_count + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count  <= '0;
      key_count   <= '0;
      value_count <= '0;
    end else if (advance) begin
      head_count  <= head_count_next;
      key_count   <= key_count_next;
      value_count <= value_count_next;
    end
  end

endmodule

// ===== rtl/core/fp32_tensor_transpose_to_fp16.sv =====
// Top level: streaming 3-D tensor transpose with optional FP32 to FP16 truncation.
// Path: a transferred word passes the input register, then the result register, to dst.
// Throughput: one word per cycle; src.ready is low only while both pipeline
//   registers are full and dst is stalled.
// Reset: rst (sync, active high) clears the position counters, both valid bits,
//   and sets the dimensions to 1 and the output format to FP32.
module fp32_tensor_transpose_to_fp16 #(
  parameter int MAX_HEADS = 64,
  parameter int MAX_DIM   = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fttf_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [fttf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  fttf_in_if.sink                           src,
  fttf_out_if.source                        dst
);

  localparam int NHW = $clog2(MAX_HEADS+1);
  localparam int NDW = $clog2(MAX_DIM+1);
  localparam int PW  = 2*NDW;
  localparam int CHW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int CDW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // ---- configuration (clamped values, plane = nk*nv kept registered) ----
  logic [NHW-1:0] nh;
  logic [NDW-1:0] nk;
  logic [NDW-1:0] nv;
  logic [PW-1:0]  plane;
  logic           half;

  fttf_cfg #(
    .MAX_HEADS (MAX_HEADS),
    .MAX_DIM   (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .nh        (nh),
    .nk        (nk),
    .nv        (nv),
    .plane     (plane),
    .half      (half)
  );

  // ---- handshake: each stage loads when it is empty or the one after it can take data ----
  logic s0_valid;
  logic out_valid;
  logic out_open;
  logic s0_open;
  logic accept;

  assign out_open  = !out_valid || dst.ready;
  assign s0_open   = !s0_valid || out_open;
  assign src.ready = s0_open;
  assign accept    = src.valid && s0_open;

  // ---- position of the word being transferred in ----
  logic [CHW-1:0] head_count;
  logic [CDW-1:0] key_count;
  logic [CDW-1:0] value_count;
  logic           last_elem;

  fttf_counter #(
    .MAX_HEADS (MAX_HEADS),
    .MAX_DIM   (MAX_DIM)
  ) u_counter (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .nh          (nh),
    .nk          (nk),
    .nv          (nv),
    .head_count  (head_count),
    .key_count   (key_count),
    .value_count (value_count),
    .last_elem   (last_elem)
  );

  // ---- input register: word plus its source coordinates ----
  logic [fttf_pkg::WORD_W-1:0] s0_word;
  logic [CHW-1:0]              s0_head;
  logic [CDW-1:0]              s0_key;
  logic [CDW-1:0]              s0_value;
  logic                        s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_open) begin
      s0_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_word  <= src.source_word;
      s0_head  <= head_count;
      s0_key   <= key_count;
      s0_value <= value_count;
      s0_last  <= last_elem;
    end
  end

  // ---- dest index = key + value*nk + head*nk*nv, mod 2^22 ----
  // Two independent multipliers, then a three-input add.
  logic [CDW+NDW-1:0]           vk_prod;
  logic [CHW+PW-1:0]            hp_prod;
  logic [fttf_pkg::INDEX_W-1:0] dest_index_next;
  logic [fttf_pkg::WORD_W-1:0]  dest_word_next;

  assign vk_prod = s0_value * nk;
  assign hp_prod = s0_head * plane;
  assign dest_index_next = fttf_pkg::INDEX_W'(s0_key)
                         + fttf_pkg::INDEX_W'(vk_prod)
                         + fttf_pkg::INDEX_W'(hp_prod);

  // FP16 result sits in the low half, upper half zero
  assign dest_word_next = half ? {16'b0, fttf_pkg::to_half(s0_word)} : s0_word;

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && out_open) begin
      dst.dest_index    <= dest_index_next;
      dst.dest_word     <= dest_word_next;
      dst.end_of_tensor <= s0_last;
    end
  end

  assign dst.valid = out_valid;

endmodule

// ===== rtl/core/fttf_checker.sv =====
// Port-level checker for the transpose block, bound to the top level.
`include "assert_macros.svh"

module fttf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [fttf_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input logic                              cfg_bit,
  input logic                              src_valid,
  input logic                              src_ready,
  input logic                              dst_valid,
  input logic                              dst_ready,
  input logic [fttf_pkg::INDEX_W-1:0]      dest_index,
  input logic [fttf_pkg::WORD_W-1:0]       dest_word,
  input logic                              end_of_tensor
);

  // shadow of the output format register
  logic half_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_mode <= 1'b0;
    end else if (cfg_we && cfg_index == fttf_pkg::CFG_TARGET_HALF) begin
      half_mode <= cfg_bit;
    end
  end

  `FTTF_ASSERT(a_out_hold, clk, rst, dst_valid && !dst_ready |=> dst_valid && $stable(dest_index) && $stable(dest_word) && $stable(end_of_tensor), "result changed while stalled")

  `FTTF_ASSERT_ALWAYS(a_no_backpressure, clk, dst_ready |-> src_ready, "input stalled while output is free")

  `FTTF_ASSERT(a_result_follows, clk, rst, (src_valid && src_ready) ##1 dst_ready |=> dst_valid, "transferred word did not reach the output")

  `FTTF_ASSERT(a_half_upper_zero, clk, rst, dst_valid && half_mode |-> dest_word[31:16] == 16'b0, "FP16 result has nonzero upper half")

endmodule

bind fp32_tensor_transpose_to_fp16 fttf_checker u_fttf_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index),
  .cfg_bit       (cfg_wdata[0]),
  .src_valid     (src.valid),
  .src_ready     (src.ready),
  .dst_valid     (dst.valid),
  .dst_ready     (dst.ready),
  .dest_index    (dst.dest_index),
  .dest_word     (dst.dest_word),
  .end_of_tensor (dst.end_of_tensor)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the streaming tensor transpose with FP32 to FP16 truncation.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_HEADS = 64;
  localparam int MAX_DIM   = 256;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold (HOLD_CYCLES) or a
  // long run of random stalls at 86 percent, far below this.
  localparam int QUIET_LIMIT  = 2000;
  // Pipeline is two registers deep; a few extra cycles cover it after a drain.
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 64;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 90;

  // One predicted output element.
  typedef struct {
    logic [fttf_pkg::INDEX_W-1:0] dest_index;
    logic [fttf_pkg::WORD_W-1:0]  dest_word;
    logic                         end_of_tensor;
  } element_t;

  // Tracks tensor position and output format, and holds the elements still owed
  // by the block in transfer order.
  class transpose_tracker;
    logic [fttf_pkg::HEADS_REG_W-1:0] heads_reg;
    logic [fttf_pkg::DIM_REG_W-1:0]   key_reg;
    logic [fttf_pkg::DIM_REG_W-1:0]   value_reg;
    logic                             half_reg;
    logic [5:0]                       head_pos;
    logic [7:0]                       key_pos;
    logic [7:0]                       value_pos;
    element_t                         owed[$];
    int                               errors;
    int                               words_in;
    int                               checked;
    int                               tensor_ends;
    int                               half_words;

    function new();
      heads_reg = 1;
      key_reg   = 1;
      value_reg = 1;
      half_reg  = 1'b0;
      head_pos  = '0;
      key_pos   = '0;
      value_pos = '0;
      errors = 0;
      words_in = 0;
      checked = 0;
      tensor_ends = 0;
      half_words = 0;
    endfunction

    function void set_reg(logic [fttf_pkg::CFG_ADDR_W-1:0] idx,
                          logic [fttf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fttf_pkg::CFG_NUM_HEADS:   heads_reg = data[fttf_pkg::HEADS_REG_W-1:0];
        fttf_pkg::CFG_KEY_DIM:     key_reg   = data[fttf_pkg::DIM_REG_W-1:0];
        fttf_pkg::CFG_VALUE_DIM:   value_reg = data[fttf_pkg::DIM_REG_W-1:0];
        fttf_pkg::CFG_TARGET_HALF: half_reg  = data[0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    static function int effective_dim(int raw, int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
    endfunction

    // truncating conversion, compared on the biased FP32 exponent
    static function logic [15:0] truncate_half(logic [fttf_pkg::WORD_W-1:0] w);
      int biased;
      biased = int'(w[30:23]);
      if (biased > fttf_pkg::F32_BIAS + fttf_pkg::F16_EMAX)
        return {w[31], 15'b0} | fttf_pkg::F16_INF;
      if (biased < fttf_pkg::F32_BIAS + fttf_pkg::F16_EMIN) return {w[31], 15'b0};
      return {w[31], 5'(biased - fttf_pkg::F32_BIAS + fttf_pkg::F16_BIAS), w[22:13]};
    endfunction

    function void take_word(logic [fttf_pkg::WORD_W-1:0] w);
      int nh, nk, nv, pos;
      logic last_v, last_k, last_h;
      element_t el;
      nh = effective_dim(int'(heads_reg), MAX_HEADS);
      nk = effective_dim(int'(key_reg), MAX_DIM);
      nv = effective_dim(int'(value_reg), MAX_DIM);
      // a counter past its dimension counts as sitting on the last index
      last_v = (int'(value_pos) + 1) >= nv;
      last_k = (int'(key_pos) + 1) >= nk;
      last_h = (int'(head_pos) + 1) >= nh;
      pos = int'(key_pos) + int'(value_pos) * nk + int'(head_pos) * nk * nv;
      el.dest_index    = fttf_pkg::INDEX_W'(pos);
      el.dest_word     = half_reg ? {16'h0, truncate_half(w)} : w;
      el.end_of_tensor = last_v && last_k && last_h;
      owed.push_back(el);
      words_in++;
      if (half_reg) half_words++;
      if (!last_v) begin
        value_pos++;
      end else begin
        value_pos = '0;
        if (!last_k) begin
          key_pos++;
        end else begin
          key_pos = '0;
          head_pos = last_h ? '0 : head_pos + 1'b1;
        end
      end
    endfunction

    function void check_element(logic [fttf_pkg::INDEX_W-1:0] idx,
                                logic [fttf_pkg::WORD_W-1:0] word,
                                logic eot);
      element_t el;
      if (owed.size() == 0) begin
        $error("result with nothing outstanding: dest_index %0d dest_word %h", idx, word);
        errors++;
        return;
      end
      el = owed.pop_front();
      checked++;
      if (eot === 1'b1) tensor_ends++;
      if (idx !== el.dest_index) begin
        $error("dest_index mismatch: expected %0d, actual %0d", el.dest_index, idx);
        errors++;
      end
      if (word !== el.dest_word) begin
        $error("dest_word mismatch: expected %h, actual %h", el.dest_word, word);
        errors++;
      end
      if (eot !== el.end_of_tensor) begin
        $error("end_of_tensor mismatch: expected %0b, actual %0b", el.end_of_tensor, eot);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [fttf_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [fttf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  fttf_in_if  src_if ();
  fttf_out_if dst_if ();

  fp32_tensor_transpose_to_fp16 #(
    .MAX_HEADS(MAX_HEADS),
    .MAX_DIM  (MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .src      (src_if),
    .dst      (dst_if)
  );

  transpose_tracker tracker;

  // Idle knobs, percent per cycle; set by the main sequence per phase.
  int send_idle_pct;
  int recv_stall_pct;
  // Long receiver hold: main bumps the request count, receiver counts it out.
  int hold_requests;
  int hold_served;
  int hold_left;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: ready changes on the falling edge only.
  initial begin : receiver
    dst_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_if.ready <= 1'b0;
      end else begin
        dst_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: both channels sampled on the rising edge, input transfer noted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (src_if.valid && src_if.ready) tracker.take_word(src_if.source_word);
      if (dst_if.valid && dst_if.ready)
        tracker.check_element(dst_if.dest_index, dst_if.dest_word, dst_if.end_of_tensor);
    end
  end

  // Watchdog: ends the run if no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("run hung: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Writes all four registers back to back; only called with the block idle.
  task automatic configure(int heads, int kdim, int vdim, int half);
    logic [fttf_pkg::CFG_DATA_W-1:0] vals[4];
    logic [fttf_pkg::CFG_ADDR_W-1:0] regs[4];
    vals[0] = fttf_pkg::CFG_DATA_W'(heads);
    vals[1] = fttf_pkg::CFG_DATA_W'(kdim);
    vals[2] = fttf_pkg::CFG_DATA_W'(vdim);
    vals[3] = fttf_pkg::CFG_DATA_W'(half);
    regs[0] = fttf_pkg::CFG_NUM_HEADS;
    regs[1] = fttf_pkg::CFG_KEY_DIM;
    regs[2] = fttf_pkg::CFG_VALUE_DIM;
    regs[3] = fttf_pkg::CFG_TARGET_HALF;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      tracker.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one word, with random idle cycles ahead of it; returns on a falling
  // edge after the transfer.
  task automatic send_word(logic [fttf_pkg::WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      src_if.valid <= 1'b0;
      @(negedge clk);
    end
    src_if.valid       <= 1'b1;
    src_if.source_word <= w;
    do @(posedge clk); while (!src_if.ready);
    @(negedge clk);
  endtask

  // Sender stops offering and waits for every owed element, then lets the
  // pipeline settle before any register write.
  task automatic drain();
    src_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random word: half uniform, the rest biased toward the FP16 exponent window
  // and its edges, or special encodings with random payload.
  function automatic logic [fttf_pkg::WORD_W-1:0] pick_word();
    logic [fttf_pkg::WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(3))
      2: w[30:23] = 8'($urandom_range(fttf_pkg::F32_BIAS + fttf_pkg::F16_EMIN - 6,
                                      fttf_pkg::F32_BIAS + fttf_pkg::F16_EMAX + 6));
      3: begin
        case ($urandom_range(2))
          0: w[30:23] = 8'hFF;   // inf or NaN
          1: w[30:23] = 8'h00;   // zero or subnormal
          default: w[30:23] = 8'($urandom_range(0, 1)
                                  ? fttf_pkg::F32_BIAS + fttf_pkg::F16_EMAX
                                  : fttf_pkg::F32_BIAS + fttf_pkg::F16_EMIN);
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin : main_seq
    logic [fttf_pkg::WORD_W-1:0] fp_edges[13];
    int mode;
    fp_edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h7FC0_0001,
                 32'hFF80_0000, 32'h8000_0000, 32'h0000_0001, 32'h477F_FFFF,
                 32'h4780_0000, 32'h3880_0000, 32'h387F_FFFF, 32'h3F80_0000,
                 32'hC049_0FDB};

    // every input known from time zero
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    src_if.valid       = 1'b0;
    src_if.source_word = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_requests      = 0;
    tracker            = new();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset dimensions and format with no writes at all.
    for (int i = 0; i < 3; i++) send_word(fp_edges[i]);
    drain();

    // 2x3x2 tensor in FP16 mode; one word past a full tensor to see the wrap.
    // Covers overflow to inf (incl. NaN), underflow to zero, both exponent edges.
    configure(2, 3, 2, 1);
    foreach (fp_edges[i]) send_word(fp_edges[i]);
    drain();

    // All dimensions zero: each acts as one, every word ends a tensor.
    configure(0, 0, 0, 0);
    send_word(32'h4049_0FDB);
    send_word(32'hBF80_0000);
    drain();

    // Oversized registers saturate to the maximum dimensions.
    configure((1 << fttf_pkg::HEADS_REG_W) - 1, (1 << fttf_pkg::DIM_REG_W) - 1,
              (1 << fttf_pkg::DIM_REG_W) - 1, 1);
    for (int i = 0; i < 3; i++) send_word(pick_word());
    drain();

    // Shrink while mid-tensor: value counter already past the new last index.
    configure(1, 2, 2, 0);
    for (int i = 0; i < 3; i++) send_word(pick_word());
    drain();

    // Random phases, cycling through the four idle modes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        2:  configure(MAX_HEADS, MAX_DIM, MAX_DIM, 1);
        5:  configure(0, 0, 0, $urandom_range(1));
        8:  configure((1 << fttf_pkg::HEADS_REG_W) - 1, (1 << fttf_pkg::DIM_REG_W) - 1,
                      $urandom_range(MAX_DIM + 1, (1 << fttf_pkg::DIM_REG_W) - 1), 0);
        11: configure(1, 1, 1, 1);
        default: configure($urandom_range(1, 4), $urandom_range(0, 7),
                           $urandom_range(1, 6), $urandom_range(1));
      endcase
      mode = ph % 4;
      send_idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 29 : 0;
      recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 29 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // full-rate phase: long receiver hold while words keep coming, so both
        // pipeline stages fill and the input gets backpressured
        if (mode == 0 && n == PHASE_ITEMS / 3) hold_requests++;
        send_word(pick_word());
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES * 2) @(negedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d elements never arrived", tracker.outstanding());
      tracker.errors++;
    end

    $display("Streamed %0d words (%0d in FP16 mode), checked %0d elements, %0d tensor ends.",
             tracker.words_in, tracker.half_words, tracker.checked, tracker.tensor_ends);
    $display("Dimensions swept: reset, zero, small, maximum, oversized, shrunk mid-tensor.");
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fttf_pkg.sv
rtl/core/fttf_if.sv
rtl/core/fttf_cfg.sv
rtl/core/fttf_counter.sv
rtl/core/fp32_tensor_transpose_to_fp16.sv
rtl/core/fttf_checker.sv
verif/tb.sv
